// ===== sv/rrsg_pkg.sv =====
// Shared widths, limits, codes and payload types of the rounded rectangle span generator.
package rrsg_pkg;

  localparam int XY_W       = 10;
  localparam int SZ_W       = 11;
  localparam int RAD_W      = 10;
  localparam int BW_W       = 6;
  localparam int CMD_W      = 11;
  localparam int MAX_RADIUS = 15;
  localparam int RC_W       = $clog2(MAX_RADIUS + 1);
  localparam int CRD_W      = 14;
  localparam int I_W        = (BW_W > RC_W) ? BW_W : RC_W;
  localparam int K_W        = (RC_W > 1) ? $clog2(RC_W) : 1;

  // Box kinds and command opcodes.
  localparam logic KIND_FILLED  = 1'b0;
  localparam logic KIND_OUTLINE = 1'b1;
  localparam logic OP_FILL      = 1'b0;
  localparam logic OP_FRAME     = 1'b1;

  typedef logic signed [CRD_W-1:0] crd_t;

  typedef struct packed {
    logic             op;
    logic [CMD_W-1:0] cmd_x;
    logic [CMD_W-1:0] cmd_y;
    logic [CMD_W-1:0] cmd_w;
    logic [CMD_W-1:0] cmd_h;
  } cmd_t;

endpackage

// ===== sv/rrsg_if.sv =====
// Valid/ready channel interfaces for box requests and drawing commands.
interface rrsg_box_if;
  import rrsg_pkg::*;

  logic             valid;
  logic             ready;
  logic             kind;
  logic [XY_W-1:0]  left;
  logic [XY_W-1:0]  top;
  logic [SZ_W-1:0]  box_width;
  logic [SZ_W-1:0]  box_height;
  logic [RAD_W-1:0] radius;
  logic [BW_W-1:0]  border;

  modport source (output valid, kind, left, top, box_width, box_height, radius, border,
                  input ready);
  modport sink (input valid, kind, left, top, box_width, box_height, radius, border,
                output ready);
endinterface

interface rrsg_cmd_if;
  import rrsg_pkg::*;

  logic             valid;
  logic             ready;
  logic             op;
  logic [CMD_W-1:0] cmd_x;
  logic [CMD_W-1:0] cmd_y;
  logic [CMD_W-1:0] cmd_w;
  logic [CMD_W-1:0] cmd_h;
  logic             last;

  modport source (output valid, op, cmd_x, cmd_y, cmd_w, cmd_h, last, input ready);
  modport sink (input valid, op, cmd_x, cmd_y, cmd_w, cmd_h, last, output ready);
endinterface

// ===== sv/rounded_rect_span_generator.sv =====
// Top level: turns one rounded box request into a stream of 2D drawing commands.
//
//   channel   direction  beat contents
//   in_box    sink       kind, left, top, box_width, box_height, radius, border
//   out_cmd   source     op, cmd_x, cmd_y, cmd_w, cmd_h, last
//
// One box is worked on at a time; in_box.ready is high only while the sequencer idles.
// Each corner row runs one or two integer square roots on a shared bit-serial root unit
// and then emits its commands. Reset is synchronous and active low and clears the
// sequencer and the valid flags. A stalled out_cmd holds one command in the output
// register and one in a pending register; the sequencer waits only when both are full.
module rounded_rect_span_generator (
  input  logic        clk,
  input  logic        rst_n,
  rrsg_box_if.sink    in_box,
  rrsg_cmd_if.source  out_cmd
);
  import rrsg_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_LOAD,
    S_ROOT,
    S_EMIT,
    S_FLUSH
  } state_t;

  // Which command the emit state is presenting.
  typedef enum logic [3:0] {
    C_FILL_ALL,
    C_FILL_MID,
    C_RING,
    C_EDGE_T,
    C_EDGE_B,
    C_EDGE_L,
    C_EDGE_R,
    C_ROW_T,
    C_ROW_B,
    C_SPL_TL,
    C_SPL_TR,
    C_SPL_BL,
    C_SPL_BR
  } sel_t;

  state_t            state_r;
  sel_t              sel_r;

  // Latched request.
  logic              kind_r;
  logic [XY_W-1:0]   x_r;
  logic [XY_W-1:0]   y_r;
  logic [SZ_W-1:0]   w_r;
  logic [SZ_W-1:0]   h_r;
  logic [RAD_W-1:0]  rad_r;
  logic [BW_W-1:0]   bw_r;

  // Working values.
  logic [RC_W-1:0]   rc_r;
  logic [RC_W-1:0]   ri_r;
  logic              ri_pos_r;
  logic [I_W-1:0]    i_r;
  logic [RC_W-1:0]   dxo_r;
  logic [RC_W-1:0]   dxi_r;
  logic              inner_r;

  // Shared square root unit.
  logic [2*RC_W-1:0] sq_n_r;
  logic [RC_W-1:0]   sq_q_r;
  logic [K_W-1:0]    sq_k_r;

  // Pending command and output register.
  logic              pend_vld_r;
  cmd_t              pend_r;
  logic              out_vld_r;
  cmd_t              out_r;
  logic              out_last_r;

  // ---------------------------------------------------------------------------------
  // Radius clamp against half width, half height and the corner limit.
  // ---------------------------------------------------------------------------------
  logic [RAD_W-1:0] rad_m1;
  logic [RAD_W-1:0] rad_m2;
  logic [RC_W-1:0]  rc_clamp;

  always_comb begin
    rad_m1   = (rad_r > RAD_W'(w_r >> 1)) ? RAD_W'(w_r >> 1) : rad_r;
    rad_m2   = (rad_m1 > RAD_W'(h_r >> 1)) ? RAD_W'(h_r >> 1) : rad_m1;
    rc_clamp = (rad_m2 > RAD_W'(MAX_RADIUS)) ? RC_W'(MAX_RADIUS) : rad_m2[RC_W-1:0];
  end

  // ---------------------------------------------------------------------------------
  // Root operand: base^2 - dy^2 is formed as (base - dy) * (base + dy).
  // ---------------------------------------------------------------------------------
  logic [RC_W-1:0]   dy;
  logic [RC_W-1:0]   root_base;
  logic [RC_W-1:0]   root_diff;
  logic [RC_W:0]     root_sum;
  logic [2*RC_W-1:0] root_prod;
  logic              split_row;
  logic              row_last;
  logic              ring_last;

  always_comb begin
    dy        = rc_r - i_r[RC_W-1:0];
    root_base = inner_r ? ri_r : rc_r;
    root_diff = root_base - dy;
    root_sum  = (RC_W+1)'(root_base) + (RC_W+1)'(dy);
    root_prod = (2*RC_W)'(root_diff) * (2*RC_W)'(root_sum);
    split_row = (kind_r == KIND_OUTLINE) && ri_pos_r && (dy <= ri_r);
    row_last  = (i_r[RC_W-1:0] == rc_r - RC_W'(1));
    ring_last = (i_r == I_W'(bw_r) - I_W'(1));
  end

  // One result bit per cycle: keep the trial bit when its square still fits.
  logic [RC_W-1:0]   trial;
  logic [2*RC_W-1:0] trial_sq;
  logic [RC_W-1:0]   q_step;

  always_comb begin
    trial    = sq_q_r | (RC_W'(1) << sq_k_r);
    trial_sq = (2*RC_W)'(trial) * (2*RC_W)'(trial);
    q_step   = (trial_sq <= sq_n_r) ? trial : sq_q_r;
  end

  // ---------------------------------------------------------------------------------
  // Candidate command. Rectangles are always emitted; spans only when not empty.
  // ---------------------------------------------------------------------------------
  crd_t xs, ys, ws, hs, rs, bs, is, dxo_s, dxi_s, y_row_t, y_row_b;
  crd_t cx, cy, cw, ch, sx1, sx2;
  logic cop;
  logic is_span;
  logic cand_vis;
  cmd_t cand;

  always_comb begin
    xs      = crd_t'(x_r);
    ys      = crd_t'(y_r);
    ws      = crd_t'(w_r);
    hs      = crd_t'(h_r);
    rs      = crd_t'(rc_r);
    bs      = crd_t'(bw_r);
    is      = crd_t'(i_r);
    dxo_s   = crd_t'(dxo_r);
    dxi_s   = crd_t'(dxi_r);
    y_row_t = ys + is;
    y_row_b = ys + hs - crd_t'(1) - is;

    cop     = OP_FILL;
    is_span = 1'b0;
    cx      = xs;
    cy      = ys;
    cw      = ws;
    ch      = hs;
    sx1     = xs + dxo_s;
    sx2     = xs + ws - crd_t'(1) - dxo_s;

    unique case (sel_r)
      C_FILL_ALL: begin
      end
      C_FILL_MID: begin
        cy = ys + rs;
        ch = hs - (rs <<< 1);
      end
      C_RING: begin
        cop = OP_FRAME;
        cx  = xs + is;
        cy  = ys + is;
        cw  = ws - (is <<< 1);
        ch  = hs - (is <<< 1);
      end
      C_EDGE_T: begin
        cx = xs + rs;
        cw = ws - (rs <<< 1);
        ch = bs;
      end
      C_EDGE_B: begin
        cx = xs + rs;
        cy = ys + hs - bs;
        cw = ws - (rs <<< 1);
        ch = bs;
      end
      C_EDGE_L: begin
        cy = ys + rs;
        cw = bs;
        ch = hs - (rs <<< 1);
      end
      C_EDGE_R: begin
        cx = xs + ws - bs;
        cy = ys + rs;
        cw = bs;
        ch = hs - (rs <<< 1);
      end
      C_ROW_T: begin
        is_span = 1'b1;
        cy      = y_row_t;
      end
      C_ROW_B: begin
        is_span = 1'b1;
        cy      = y_row_b;
      end
      C_SPL_TL: begin
        is_span = 1'b1;
        cy      = y_row_t;
        sx2     = xs + dxi_s - crd_t'(1);
      end
      C_SPL_TR: begin
        is_span = 1'b1;
        cy      = y_row_t;
        sx1     = xs + ws - dxi_s;
      end
      C_SPL_BL: begin
        is_span = 1'b1;
        cy      = y_row_b;
        sx2     = xs + dxi_s - crd_t'(1);
      end
      C_SPL_BR: begin
        is_span = 1'b1;
        cy      = y_row_b;
        sx1     = xs + ws - dxi_s;
      end
      default: begin
      end
    endcase

    cand_vis = 1'b1;
    if (is_span) begin
      cx       = sx1;
      cw       = sx2 - sx1 + crd_t'(1);
      ch       = crd_t'(1);
      cand_vis = (sx1 <= sx2);
    end

    // Coordinates wrap to 11 bits; a size that is not positive goes out as zero.
    cand.op    = cop;
    cand.cmd_x = cx[CMD_W-1:0];
    cand.cmd_y = cy[CMD_W-1:0];
    cand.cmd_w = (cw <= crd_t'(0)) ? '0 : cw[CMD_W-1:0];
    cand.cmd_h = (ch <= crd_t'(0)) ? '0 : ch[CMD_W-1:0];
  end

  // The pending command moves on when the output register is empty or being taken.
  logic slot_free;
  logic emit_go;
  logic out_load;

  assign slot_free = !out_vld_r || out_cmd.ready;
  assign emit_go   = !cand_vis || !pend_vld_r || slot_free;
  assign out_load  = pend_vld_r &&
                     (((state_r == S_EMIT) && emit_go && cand_vis) ||
                      ((state_r == S_FLUSH) && slot_free));

  // ---------------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      out_vld_r <= out_load || (out_vld_r && !out_cmd.ready);

      unique case (state_r)
        S_IDLE: begin
          if (in_box.valid) begin
            kind_r  <= in_box.kind;
            x_r     <= in_box.left;
            y_r     <= in_box.top;
            w_r     <= in_box.box_width;
            h_r     <= in_box.box_height;
            rad_r   <= in_box.radius;
            bw_r    <= in_box.border;
            state_r <= S_SETUP;
          end
        end

        S_SETUP: begin
          rc_r     <= rc_clamp;
          ri_r     <= rc_clamp - bw_r[RC_W-1:0];
          ri_pos_r <= (BW_W'(rc_clamp) > bw_r);
          i_r      <= '0;
          inner_r  <= 1'b0;
          if (kind_r == KIND_FILLED) begin
            if (rc_clamp == '0) begin
              sel_r   <= C_FILL_ALL;
              state_r <= S_EMIT;
            end else begin
              state_r <= S_LOAD;
            end
          end else if (bw_r == '0) begin
            state_r <= S_IDLE;
          end else if (rc_clamp == '0) begin
            sel_r   <= C_RING;
            state_r <= S_EMIT;
          end else begin
            sel_r   <= C_EDGE_T;
            state_r <= S_EMIT;
          end
        end

        S_LOAD: begin
          sq_n_r  <= root_prod;
          sq_q_r  <= '0;
          sq_k_r  <= K_W'(RC_W - 1);
          state_r <= S_ROOT;
        end

        S_ROOT: begin
          sq_q_r <= q_step;
          if (sq_k_r == '0) begin
            if (!inner_r) begin
              dxo_r <= rc_r - q_step;
              if (split_row) begin
                inner_r <= 1'b1;
                state_r <= S_LOAD;
              end else begin
                sel_r   <= C_ROW_T;
                state_r <= S_EMIT;
              end
            end else begin
              // The inner inset is the border plus the inner circle's own inset.
              dxi_r   <= rc_r - q_step;
              sel_r   <= C_SPL_TL;
              state_r <= S_EMIT;
            end
          end else begin
            sq_k_r <= sq_k_r - K_W'(1);
          end
        end

        S_EMIT: begin
          if (emit_go) begin
            if (cand_vis) begin
              pend_r     <= cand;
              pend_vld_r <= 1'b1;
              if (pend_vld_r) begin
                out_r      <= pend_r;
                out_last_r <= 1'b0;
              end
            end

            unique case (sel_r)
              C_FILL_ALL, C_FILL_MID: state_r <= S_FLUSH;
              C_RING: begin
                if (ring_last) begin
                  state_r <= S_FLUSH;
                end else begin
                  i_r <= i_r + I_W'(1);
                end
              end
              C_EDGE_T: sel_r <= C_EDGE_B;
              C_EDGE_B: sel_r <= C_EDGE_L;
              C_EDGE_L: sel_r <= C_EDGE_R;
              C_EDGE_R: begin
                i_r     <= '0;
                inner_r <= 1'b0;
                state_r <= S_LOAD;
              end
              C_ROW_T:  sel_r <= C_ROW_B;
              C_SPL_TL: sel_r <= C_SPL_TR;
              C_SPL_TR: sel_r <= C_SPL_BL;
              C_SPL_BL: sel_r <= C_SPL_BR;
              C_ROW_B, C_SPL_BR: begin
                if (row_last) begin
                  if (kind_r == KIND_OUTLINE) begin
                    state_r <= S_FLUSH;
                  end else begin
                    sel_r <= C_FILL_MID;
                  end
                end else begin
                  i_r     <= i_r + I_W'(1);
                  inner_r <= 1'b0;
                  state_r <= S_LOAD;
                end
              end
              default: state_r <= S_FLUSH;
            endcase
          end
        end

        S_FLUSH: begin
          // The command still pending is the box's final one.
          if (!pend_vld_r) begin
            state_r <= S_IDLE;
          end else if (slot_free) begin
            out_r      <= pend_r;
            out_last_r <= 1'b1;
            pend_vld_r <= 1'b0;
            state_r    <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_box.ready  = (state_r == S_IDLE);
  assign out_cmd.valid = out_vld_r;
  assign out_cmd.op    = out_r.op;
  assign out_cmd.cmd_x = out_r.cmd_x;
  assign out_cmd.cmd_y = out_r.cmd_y;
  assign out_cmd.cmd_w = out_r.cmd_w;
  assign out_cmd.cmd_h = out_r.cmd_h;
  assign out_cmd.last  = out_last_r;

`ifndef SYNTHESIS
  // A new box never starts while a command of the previous one is still held back.
  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_box.ready |-> !pend_vld_r)
    else $error("box accepted with a command still pending");

  // Corner rows stay inside the clamped radius.
  a_row_in_radius: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD || state_r == S_ROOT) |-> (I_W'(rc_r) > i_r))
    else $error("corner row beyond the radius");

  // The inner circle never lies outside the outer one on a split row.
  a_inner_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (sel_r == C_SPL_TL || sel_r == C_SPL_TR ||
                           sel_r == C_SPL_BL || sel_r == C_SPL_BR))
      |-> (dxi_r >= dxo_r))
    else $error("inner inset smaller than outer inset");

  // A command is never dropped: the output register is refilled only when free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_cmd.ready) |=> (out_vld_r && $stable(out_r) && $stable(out_last_r)))
    else $error("output command overwritten while stalled");
`endif

endmodule

// ===== dv/tb_rounded_rect_span_generator.sv =====
// Self-checking testbench for the rounded rectangle span generator and its predictor.
module tb_rounded_rect_span_generator;
  timeunit 1ns;
  timeprecision 1ps;
  import rrsg_pkg::*;

  // No box can produce more commands than this; extra ones are dropped.
  localparam int MAX_CMDS     = 64;
  localparam int RANDOM_BOXES = 450;
  // Quiet tail after the last expected command, so that a late stray command is
  // still caught.
  localparam int DRAIN_CYCLES = 400;
  // Cycles without any beat on either channel before the run is declared hung.
  localparam int STALL_LIMIT  = 4000;
  // Window of accepted boxes in which neither side inserts gaps.
  localparam int STEADY_FROM  = 150;
  localparam int STEADY_TO    = 250;

  typedef struct {
    bit              kind;
    bit [XY_W-1:0]   left;
    bit [XY_W-1:0]   top;
    bit [SZ_W-1:0]   box_width;
    bit [SZ_W-1:0]   box_height;
    bit [RAD_W-1:0]  radius;
    bit [BW_W-1:0]   border;
  } box_req_t;

  typedef struct packed {
    cmd_t cmd;
    logic last;
  } cmd_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  rrsg_box_if box_if ();
  rrsg_cmd_if cmd_if ();

  rounded_rect_span_generator i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_box  (box_if),
    .out_cmd (cmd_if)
  );

  always #1 clk = ~clk;

  box_req_t  queued_boxes[$];
  box_req_t  box_on_bus;
  cmd_beat_t box_cmds[$];
  cmd_beat_t pending_cmds[$];
  int        total_boxes;
  int        boxes_taken  = 0;
  int        err_cnt      = 0;
  int        quiet_cycles = 0;

  // ---------------------------------------------------------------------------
  // Command predictor
  // ---------------------------------------------------------------------------

  // Horizontal inset of a corner row: r minus the integer square root of
  // r*r - dy*dy, with dy the row's distance from the corner circle's center.
  function automatic int arc_inset(int r, int dy);
    int n;
    int s;
    n = r * r - dy * dy;
    s = 0;
    while ((s + 1) * (s + 1) <= n) s++;
    return r - s;
  endfunction

  // Coordinates wrap to 11 bits; sizes at or below zero come out as zero.
  function automatic void push_cmd(bit op, int x, int y, int w, int h);
    cmd_beat_t c;
    if (box_cmds.size() >= MAX_CMDS) return;
    c.cmd.op    = op;
    c.cmd.cmd_x = x[CMD_W-1:0];
    c.cmd.cmd_y = y[CMD_W-1:0];
    c.cmd.cmd_w = (w <= 0) ? '0 : w[CMD_W-1:0];
    c.cmd.cmd_h = (h <= 0) ? '0 : h[CMD_W-1:0];
    c.last      = 1'b0;
    box_cmds.push_back(c);
  endfunction

  // A one-row span from x1 to x2 inclusive; an empty span emits nothing.
  function automatic void push_span(int x1, int x2, int y);
    if (x1 <= x2) push_cmd(OP_FILL, x1, y, x2 - x1 + 1, 1);
  endfunction

  // Works out every command of one accepted box and queues them for checking.
  function automatic void predict_box_cmds(box_req_t b);
    int x, y, w, h, r, bw, ri, dy, dxo, dxi, x0, x1;
    box_cmds.delete();
    x  = int'(b.left);
    y  = int'(b.top);
    w  = int'(b.box_width);
    h  = int'(b.box_height);
    bw = int'(b.border);
    r  = int'(b.radius);
    if (r > w / 2) r = w / 2;
    if (r > h / 2) r = h / 2;
    if (r > MAX_RADIUS) r = MAX_RADIUS;

    if (b.kind == KIND_FILLED) begin
      if (r == 0) begin
        push_cmd(OP_FILL, x, y, w, h);
      end else begin
        // Top and bottom corner rows alternate, then the full-width middle.
        for (int i = 0; i < r; i++) begin
          dxo = arc_inset(r, r - i);
          push_span(x + dxo, x + w - 1 - dxo, y + i);
          push_span(x + dxo, x + w - 1 - dxo, y + h - 1 - i);
        end
        push_cmd(OP_FILL, x, y + r, w, h - 2 * r);
      end
    end else if (bw > 0) begin
      if (r == 0) begin
        // Square corners: nested one-pixel frames, one per border pixel.
        for (int i = 0; i < bw; i++) begin
          push_cmd(OP_FRAME, x + i, y + i, w - 2 * i, h - 2 * i);
        end
      end else begin
        ri = r - bw;
        push_cmd(OP_FILL, x + r, y, w - 2 * r, bw);
        push_cmd(OP_FILL, x + r, y + h - bw, w - 2 * r, bw);
        push_cmd(OP_FILL, x, y + r, bw, h - 2 * r);
        push_cmd(OP_FILL, x + w - bw, y + r, bw, h - 2 * r);
        for (int i = 0; i < r; i++) begin
          dy  = r - i;
          dxo = arc_inset(r, dy);
          x0  = x + dxo;
          x1  = x + w - 1 - dxo;
          if (ri > 0 && dy <= ri) begin
            // The inner arc reaches this row, so each side gets its own span.
            dxi = (r - ri) + arc_inset(ri, dy);
            push_span(x0, x + dxi - 1, y + i);
            push_span(x + w - dxi, x1, y + i);
            push_span(x0, x + dxi - 1, y + h - 1 - i);
            push_span(x + w - dxi, x1, y + h - 1 - i);
          end else begin
            push_span(x0, x1, y + i);
            push_span(x0, x1, y + h - 1 - i);
          end
        end
      end
    end

    if (box_cmds.size() > 0) box_cmds[box_cmds.size() - 1].last = 1'b1;
    foreach (box_cmds[k]) pending_cmds.push_back(box_cmds[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_box(bit k, int l, int t, int w, int h, int r, int b);
    box_req_t req;
    req.kind       = k;
    req.left       = XY_W'(l);
    req.top        = XY_W'(t);
    req.box_width  = SZ_W'(w);
    req.box_height = SZ_W'(h);
    req.radius     = RAD_W'(r);
    req.border     = BW_W'(b);
    queued_boxes.push_back(req);
  endtask

  // Mostly small sizes, so that the radius clamp and the corner rows matter;
  // the full range and the edges show up as well.
  function automatic int pick_size();
    case ($urandom_range(0, 9))
      6, 7:    return $urandom_range(0, 1024);
      8:       return 1024;
      9:       return $urandom_range(0, 3);
      default: return $urandom_range(0, 40);
    endcase
  endfunction

  task automatic add_random_box();
    int r;
    int b;
    r = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 20);
    b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 20);
    add_box(1'($urandom_range(0, 1)), $urandom_range(0, 1023), $urandom_range(0, 1023),
            pick_size(), pick_size(), r, b);
  endtask

  // About one cycle in five is a gap, except for a steady stretch mid-run.
  function automatic bit want_gap();
    if (boxes_taken >= STEADY_FROM && boxes_taken < STEADY_TO) return 1'b0;
    return $urandom_range(0, 99) < 20;
  endfunction

  // ---------------------------------------------------------------------------
  // Box driver: offers the next queued box once the current beat has gone.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      box_if.valid <= 1'b0;
    end else if (!box_if.valid || box_if.ready) begin
      if (box_if.valid) begin
        predict_box_cmds(box_on_bus);
        boxes_taken++;
      end
      if (queued_boxes.size() > 0 && !want_gap()) begin
        box_on_bus         = queued_boxes.pop_front();
        box_if.valid      <= 1'b1;
        box_if.kind       <= box_on_bus.kind;
        box_if.left       <= box_on_bus.left;
        box_if.top        <= box_on_bus.top;
        box_if.box_width  <= box_on_bus.box_width;
        box_if.box_height <= box_on_bus.box_height;
        box_if.radius     <= box_on_bus.radius;
        box_if.border     <= box_on_bus.border;
      end else begin
        box_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Command monitor: checks each accepted beat against the oldest prediction
  // and stalls the output at random.
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, int expected, int actual);
    if (expected !== actual) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
      err_cnt++;
    end
  endtask

  task automatic check_cmd();
    cmd_beat_t want;
    if (pending_cmds.size() == 0) begin
      $error("unexpected command: op %0d x %0d y %0d w %0d h %0d last %0d",
             cmd_if.op, cmd_if.cmd_x, cmd_if.cmd_y, cmd_if.cmd_w, cmd_if.cmd_h, cmd_if.last);
      err_cnt++;
      return;
    end
    want = pending_cmds.pop_front();
    check_field("op",    int'(want.cmd.op),    int'(cmd_if.op));
    check_field("cmd_x", int'(want.cmd.cmd_x), int'(cmd_if.cmd_x));
    check_field("cmd_y", int'(want.cmd.cmd_y), int'(cmd_if.cmd_y));
    check_field("cmd_w", int'(want.cmd.cmd_w), int'(cmd_if.cmd_w));
    check_field("cmd_h", int'(want.cmd.cmd_h), int'(cmd_if.cmd_h));
    check_field("last",  int'(want.last),      int'(cmd_if.last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_if.ready <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) check_cmd();
      cmd_if.ready <= !want_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: a long run of cycles with no beat on either side means a hang.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if ((box_if.valid && box_if.ready) || (cmd_if.valid && cmd_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;

    // Filled boxes: square corners over the whole screen, the largest radius
    // clamped, an empty box, a 2x2 box whose corner spans are all empty,
    // a full circle-cornered square and a radius cut by the width.
    add_box(KIND_FILLED,     0,    0, 1024, 1024,    0,  0);
    add_box(KIND_FILLED,  1023, 1023, 1024, 1024, 1023, 63);
    add_box(KIND_FILLED,   512,  511,    0,    0,    5, 42);
    add_box(KIND_FILLED,     3,    4,    2,    2,    1,  0);
    add_box(KIND_FILLED,   100,  200,   30,   30,   15,  0);
    add_box(KIND_FILLED,   341,  682,    7,   40,   10, 21);
    add_box(KIND_FILLED,  1023,    0,    1, 1024,    7,  1);
    add_box(KIND_FILLED,    10,   20,   31,    3,  512,  0);
    // Outlines: zero border draws nothing; square corners with the thickest
    // border; a border thicker than the box, so frames shrink to nothing.
    add_box(KIND_OUTLINE,   50,   60,  100,  100,    8,  0);
    add_box(KIND_OUTLINE,    0,    0, 1024, 1024,    0, 63);
    add_box(KIND_OUTLINE,  700,  300,    4,    6,    0,  5);
    // Rounded outlines: the inner arc splits the corner rows, the inner arc
    // vanishes, a border past the box edge drives coordinates negative, and
    // the smallest boxes that still round.
    add_box(KIND_OUTLINE,  200,  100,  100,   80,   15,  3);
    add_box(KIND_OUTLINE,  300,  400,   64,   64,   15, 15);
    add_box(KIND_OUTLINE,    0,    0,   30,   30,   15, 63);
    add_box(KIND_OUTLINE,  123,  456,    8,    8,    4,  1);
    add_box(KIND_OUTLINE, 1023, 1023,    2,    2,    1,  1);
    add_box(KIND_OUTLINE,  640,  480, 1024,   17, 1023,  2);
    add_box(KIND_OUTLINE,  999,   33,   21,   50,   10,  4);
    add_box(KIND_OUTLINE,   17,  990,   40,   40,   12, 11);

    repeat (RANDOM_BOXES) add_random_box();
    total_boxes = queued_boxes.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Every box goes in, every predicted command comes back, and then a quiet
    // tail makes sure nothing extra follows.
    while (boxes_taken < total_boxes) @(posedge clk);
    while (pending_cmds.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== rounded_rect_span_generator.f =====
sv/rrsg_pkg.sv
sv/rrsg_if.sv
sv/rounded_rect_span_generator.sv
dv/tb_rounded_rect_span_generator.sv
